// ===== src/assert_macros.svh =====
// Assertion macros shared by the life automaton engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define LAE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LAE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/lae_pkg.sv =====
// Types and constants of the life automaton engine.
package lae_pkg;

   localparam int SIZE_W   = 7;
   localparam int ACTION_W = 2;
   localparam int COORD_W  = 6;

   localparam logic [SIZE_W-1:0] BOARD_SIZE_RESET = 7'd64;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;

   // Neighbor counts of the B3/S23 rule
   localparam logic [3:0] COUNT_BIRTH = 4'd3;
   localparam logic [3:0] COUNT_KEEP  = 4'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  column;
      logic                new_value;
   } lae_req_type;

   typedef struct packed {
      logic read_value;
      logic out_of_range;
   } lae_rsp_type;

   // Command bundle toward the board memory
   typedef struct packed {
      logic rd_en;
      logic rd_bank;
      logic wr_en;
      logic wr_bank;
      logic clr_en;
      logic clr_bank;
   } lae_mem_ctl_type;

endpackage

// ===== src/lae_bank_mem.sv =====
// Double-banked board memory with per-row valid bits and registered read.
module lae_bank_mem #(
   parameter int WIDTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lae_pkg::lae_mem_ctl_type    ctl,
   input  logic [$clog2(WIDTH)-1:0]    rd_row,
   input  logic [$clog2(WIDTH)-1:0]    wr_row,
   input  logic [WIDTH-1:0]            wr_data,
   output logic [WIDTH-1:0]            rd_data
);
   import lae_pkg::*;

   logic [WIDTH-1:0] mem_ff [2][WIDTH];
   logic [WIDTH-1:0] valid_ff [2];
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   // Row valid bits: a whole bank clears at once, a write marks its row
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= '0;
         valid_ff[1] <= '0;
      end else begin
         if (ctl.clr_en) begin
            valid_ff[ctl.clr_bank] <= '0;
         end
         if (ctl.wr_en) begin
            valid_ff[ctl.wr_bank][wr_row] <= 1'b1;
         end
      end
   end

   // Storage array, one write and one read per cycle
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.wr_bank][wr_row] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= mem_ff[ctl.rd_bank][rd_row];
         rd_valid_ff <= valid_ff[ctl.rd_bank][rd_row];
      end
   end

   // A row never written since its bank was cleared reads as all dead
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== src/lae_row_next.sv =====
// Next-generation logic for one board row from a three-row window.
module lae_row_next #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0] above,
   input  logic [WIDTH-1:0] mid,
   input  logic [WIDTH-1:0] below,
   input  logic [WIDTH-1:0] col_mask,
   output logic [WIDTH-1:0] next_row
);
   import lae_pkg::*;

   logic [WIDTH-1:0] above_l, above_r, mid_l, mid_r, below_l, below_r;
   logic [WIDTH-1:0] alive;
   logic [3:0]       count [WIDTH];

   // Column neighbors, zero beyond either edge
   assign above_l = above << 1;
   assign above_r = above >> 1;
   assign mid_l   = mid << 1;
   assign mid_r   = mid >> 1;
   assign below_l = below << 1;
   assign below_r = below >> 1;

   // Per-cell count and rule
   always_comb begin
      for (int c = 0; c < WIDTH; c++) begin
         count[c] = 4'(above_l[c]) + 4'(above[c]) + 4'(above_r[c])
                  + 4'(mid_l[c]) + 4'(mid_r[c])
                  + 4'(below_l[c]) + 4'(below[c]) + 4'(below_r[c]);
         if (count[c] == COUNT_BIRTH) begin
            alive[c] = 1'b1;
         end else if (count[c] == COUNT_KEEP) begin
            alive[c] = mid[c];
         end else begin
            alive[c] = 1'b0;
         end
      end
   end

   assign next_row = alive & col_mask;

endmodule

// ===== src/life_automaton_engine.sv =====
// Life automaton engine: B3/S23 board with cell access and generation step.
//
// Requests arrive on req_valid/req_stall with an lae_req_type payload: write a
// cell, read a cell, or advance the board one generation. Each request gives
// exactly one transfer on rsp_valid/rsp_stall (read value and range flag).
// csr_wr_en/csr_wr_data set the board side (0 acts as 1, above MAX_SIDE acts as
// MAX_SIDE); write it only while no request is outstanding.
// One request is worked on at a time; req_stall is high from acceptance until
// its result is loaded into the output register.
// An in-range read or write does one memory read, then for a write modifies and
// writes the row back; an out-of-range access or an unused action goes straight
// to the result. An advance streams one row per cycle through the single memory
// read port. The next request can be taken in the cycle after a result is
// loaded, so one request never overlaps the next.
// A finished result waits in the output register while rsp_stall is high; the
// next request is accepted meanwhile, and its own result waits for the slot.
// Reset clears every cell to dead at once through per-row valid bits, selects
// bank zero, sets the side to 64 and drops rsp_valid; no clearing pass runs.
`include "assert_macros.svh"

module life_automaton_engine #(
   parameter int MAX_SIDE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  lae_pkg::lae_req_type        req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lae_pkg::lae_rsp_type        rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [lae_pkg::SIZE_W-1:0]  csr_wr_data
);
   import lae_pkg::*;

   localparam int ROW_W = $clog2(MAX_SIDE);
   localparam int CNT_W = $clog2(MAX_SIDE + 2);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MODIFY = 5'b00010,
      ST_READ   = 5'b00100,
      ST_ADV    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic                bank_ff, bank_in;
   logic [SIZE_W-1:0]   board_size_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   lae_rsp_type         rsp_ff, rsp_in;
   lae_rsp_type         res_ff, res_in;
   lae_req_type         req_ff, req_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MAX_SIDE-1:0] mask_ff, mask_in;
   logic [MAX_SIDE-1:0] above_ff, above_in;
   logic [MAX_SIDE-1:0] mid_ff, mid_in;

   logic                req_xfer;
   logic [SIZE_W-1:0]   n_eff;
   logic                in_range;
   logic                is_access;
   logic [MAX_SIDE-1:0] mask_new;
   logic [CNT_W-1:0]    cnt_m1, cnt_m2, n_p1;
   logic [MAX_SIDE-1:0] below;
   logic [MAX_SIDE-1:0] next_row;
   logic [MAX_SIDE-1:0] rmw_row;
   logic [MAX_SIDE-1:0] rd_data;
   logic [ROW_W-1:0]    rd_row, wr_row;
   logic [MAX_SIDE-1:0] wr_data;
   lae_mem_ctl_type     mem_ctl;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Effective side, range check and column mask for the incoming request
   always_comb begin
      if (board_size_ff == '0) begin
         n_eff = SIZE_W'(1);
      end else if (board_size_ff > SIZE_W'(MAX_SIDE)) begin
         n_eff = SIZE_W'(MAX_SIDE);
      end else begin
         n_eff = board_size_ff;
      end
      in_range  = (SIZE_W'(req_payload.row) < n_eff) && (SIZE_W'(req_payload.column) < n_eff);
      is_access = (req_payload.action == ACT_WRITE) || (req_payload.action == ACT_READ);
      for (int c = 0; c < MAX_SIDE; c++) begin
         mask_new[c] = (SIZE_W'(c) < n_eff);
      end
   end

   // Advance window bookkeeping
   assign cnt_m1 = cnt_ff - CNT_W'(1);
   assign cnt_m2 = cnt_ff - CNT_W'(2);
   assign n_p1   = n_ff + CNT_W'(1);
   assign below  = ((cnt_ff != '0) && (cnt_m1 < n_ff)) ? (rd_data & mask_ff) : '0;

   // Cell write merged into the row read back
   always_comb begin
      rmw_row = rd_data;
      rmw_row[req_ff.column[ROW_W-1:0]] = req_ff.new_value;
   end

   lae_row_next #(
      .WIDTH (MAX_SIDE)
   ) u_row_next (
      .above    (above_ff),
      .mid      (mid_ff),
      .below    (below),
      .col_mask (mask_ff),
      .next_row (next_row)
   );

   lae_bank_mem #(
      .WIDTH (MAX_SIDE)
   ) u_bank_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_row  (rd_row),
      .wr_row  (wr_row),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // Sequencer: next state, memory commands and result
   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      req_in       = req_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      mask_in      = mask_ff;
      above_in     = above_ff;
      mid_in       = mid_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_ctl      = '0;
      rd_row       = '0;
      wr_row       = '0;
      wr_data      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               req_in   = req_payload;
               n_in     = CNT_W'(n_eff);
               mask_in  = mask_new;
               cnt_in   = '0;
               above_in = '0;
               mid_in   = '0;
               res_in   = '0;
               if (is_access && in_range) begin
                  mem_ctl.rd_en   = 1'b1;
                  mem_ctl.rd_bank = bank_ff;
                  rd_row          = req_payload.row[ROW_W-1:0];
                  state_in = (req_payload.action == ACT_WRITE) ? ST_MODIFY : ST_READ;
               end else if (req_payload.action == ACT_ADVANCE) begin
                  mem_ctl.clr_en   = 1'b1;
                  mem_ctl.clr_bank = ~bank_ff;
                  state_in         = ST_ADV;
               end else begin
                  res_in.out_of_range = is_access;
                  state_in            = ST_FINISH;
               end
            end
         end
         ST_MODIFY: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_bank = bank_ff;
            wr_row          = req_ff.row[ROW_W-1:0];
            wr_data         = rmw_row;
            state_in        = ST_FINISH;
         end
         ST_READ: begin
            res_in.read_value = rd_data[req_ff.column[ROW_W-1:0]];
            state_in          = ST_FINISH;
         end
         ST_ADV: begin
            // Read row cnt, compute row cnt-2 from the window
            if (cnt_ff < n_ff) begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_bank = bank_ff;
               rd_row          = cnt_ff[ROW_W-1:0];
            end
            if (cnt_ff >= CNT_W'(2)) begin
               mem_ctl.wr_en   = 1'b1;
               mem_ctl.wr_bank = ~bank_ff;
               wr_row          = cnt_m2[ROW_W-1:0];
               wr_data         = next_row;
            end
            above_in = mid_ff;
            mid_in   = below;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == n_p1) begin
               bank_in  = ~bank_ff;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bank_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         board_size_ff <= BOARD_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            board_size_ff <= csr_wr_data;
         end
      end
   end

   // Payload and datapath registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      n_ff     <= n_in;
      cnt_ff   <= cnt_in;
      mask_ff  <= mask_in;
      above_ff <= above_in;
      mid_ff   <= mid_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   // An advance never writes the bank it is reading from
   `LAE_ASSERT(a_adv_bank_split, (state_ff == ST_ADV && mem_ctl.wr_en) |-> (mem_ctl.wr_bank != bank_ff), "advance wrote its source bank")
   // The current bank flips only at the end of an advance
   `LAE_ASSERT(a_bank_flip, (bank_ff != $past(bank_ff)) |-> ($past(state_ff) == ST_ADV), "bank changed outside an advance")
   // One request at a time: an accepted request blocks the next
   `LAE_ASSERT(a_one_in_flight, req_xfer |=> req_stall, "request accepted while another in flight")
   // No result is offered right after reset
   `LAE_ASSERT_ALWAYS(a_rsp_reset, reset |=> !rsp_valid, "result valid after reset")

endmodule
